FILE: rtl/edf_pkg.sv
// Package for the evidence display follower: register indexes, widths and reset values.
`default_nettype none
package edf_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int THR_W   = 7;
  localparam int STEP_W  = 4;
  localparam int LIMIT_W = 16;
  localparam int EVID_W  = 8;
  localparam int SRC_W   = 8;
  localparam int SEQ_W   = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INCREMENT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEAK      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CANCEL    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT     = 3'd4;

  localparam logic [THR_W-1:0]   THR_RESET   = 7'd5;
  localparam logic [STEP_W-1:0]  INC_RESET   = 4'd1;
  localparam logic [STEP_W-1:0]  LEAK_RESET  = 4'd1;
  localparam logic [STEP_W-1:0]  REV_RESET   = 4'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd8;

  localparam logic [EVID_W-1:0] EVID_MAX = 8'd127;

  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_ZERO = 2'b00;
  localparam logic [1:0] DIR_NEG  = 2'b11;

endpackage
`default_nettype wire

FILE: rtl/evidence_display_follower.sv
// Evidence display follower: input register, single-pass update logic and result register.
//
//  channel | dir | handshake          | payload
//  s       | in  | s_tvalid/s_tready  | s_tdata sample fields, s_tuser flags
//  m       | out | m_tvalid/m_tready  | m_tdata counts and evidence, m_tuser flags
//  cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One word per cycle while the output is not stalled; an accepted word waits in the
//  input register and is loaded into the result register when it moves on.
//  The follower state is read and written by the one update stage between the input
//  and result registers, so words follow each other every cycle while not stalled.
//  rst clears the state, both valid flags and loads the register defaults.
//  A stalled result holds in the output register; the input register takes a
//  word while it is empty or while its word moves on in the same cycle.
`default_nettype none
module evidence_display_follower
  import edf_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     s_tvalid,
  output logic                                    s_tready,
  // source_id, base_cnt, target_cnt, sample_seq
  input  wire  [((SRC_W+2*COUNT_WIDTH+SEQ_W+7)/8)*8-1:0] s_tdata,
  // sample_valid, is_stable, is_active
  input  wire  [2:0]                              s_tuser,
  output logic                                    m_tvalid,
  input  wire                                     m_tready,
  // desired_out, shown_count, delta_out, evidence_out, dir_out
  output logic [((3*COUNT_WIDTH+EVID_W+3+7)/8)*8-1:0] m_tdata,
  // locked_out, initialized_out, stable_echo, active_echo, jumped
  output logic [4:0]                              m_tuser,
  input  wire                                     cfg_valid,
  output logic                                    cfg_ready,
  input  wire  [CFG_INDEX_W-1:0]                  cfg_index,
  input  wire  [CFG_DATA_W-1:0]                   cfg_data
);

  localparam int CW       = COUNT_WIDTH;
  localparam int DW       = CW + 1;
  localparam int MW       = (DW > LIMIT_W) ? DW : LIMIT_W;
  localparam int OUT_BITS = 3 * CW + EVID_W + 3;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // configuration
  logic [THR_W-1:0]   thr_level;
  logic [STEP_W-1:0]  inc_step;
  logic [STEP_W-1:0]  zero_leak;
  logic [STEP_W-1:0]  reverse_cancel;
  logic [LIMIT_W-1:0] large_step_limit;

  // input register
  logic                    s1_valid;
  logic [SRC_W-1:0]        s1_src;
  logic signed [CW-1:0]    s1_base;
  logic signed [CW-1:0]    s1_want;
  logic [SEQ_W-1:0]        s1_seq;
  logic                    s1_sample_valid;
  logic                    s1_stable;
  logic                    s1_active;
  logic                    s1_advance;

  // follower state
  logic signed [CW-1:0]     shown_reg;
  logic signed [EVID_W-1:0] evidence_reg;
  logic [SEQ_W-1:0]         last_seq_reg;
  logic [SRC_W-1:0]         source_reg;
  logic                     init_flag;
  logic                     lock_flag;

  // update logic
  logic                     reinit;
  logic signed [DW-1:0]     delta_cur;
  logic signed [DW-1:0]     delta_base;
  logic [DW-1:0]            delta_mag;
  logic                     big_step;
  logic                     dir_neg;
  logic                     dir_nz;
  logic                     e_neg;
  logic [EVID_W-1:0]        e_mag;
  logic [EVID_W-1:0]        lim_sum;
  logic [EVID_W-1:0]        lim;
  logic [EVID_W:0]          grow;
  logic                     gather;
  logic [EVID_W-1:0]        g_mag;
  logic                     g_neg;
  logic [EVID_W-1:0]        sel_mag;
  logic                     sel_neg;
  logic signed [EVID_W-1:0] ev_sel;
  logic                     take_step;

  logic signed [CW-1:0]     shown_next;
  logic signed [EVID_W-1:0] evidence_next;
  logic                     init_next;
  logic                     lock_next;
  logic                     jump_next;
  logic signed [DW-1:0]     delta_next;
  logic [1:0]               dir_next;

  // result register
  logic signed [CW-1:0]     r_want;
  logic signed [CW-1:0]     r_shown;
  logic signed [DW-1:0]     r_delta;
  logic signed [EVID_W-1:0] r_evid;
  logic [1:0]               r_dir;
  logic                     r_lock;
  logic                     r_init;
  logic                     r_stable;
  logic                     r_active;
  logic                     r_jump;
  logic [OUT_BITS-1:0]      out_packed;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_level          <= THR_RESET;
      inc_step           <= INC_RESET;
      zero_leak          <= LEAK_RESET;
      reverse_cancel     <= REV_RESET;
      large_step_limit   <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_level          <= cfg_data[THR_W-1:0];
        CFG_INCREMENT: inc_step           <= cfg_data[STEP_W-1:0];
        CFG_LEAK:      zero_leak          <= cfg_data[STEP_W-1:0];
        CFG_CANCEL:    reverse_cancel     <= cfg_data[STEP_W-1:0];
        CFG_LIMIT:     large_step_limit   <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_src          <= s_tdata[SRC_W-1:0];
      s1_base         <= s_tdata[SRC_W+CW-1:SRC_W];
      s1_want         <= s_tdata[SRC_W+2*CW-1:SRC_W+CW];
      s1_seq          <= s_tdata[SRC_W+2*CW+SEQ_W-1:SRC_W+2*CW];
      s1_sample_valid <= s_tuser[0];
      s1_stable       <= s_tuser[1];
      s1_active       <= s_tuser[2];
    end
  end

  always_comb begin
    reinit     = !init_flag || !s1_sample_valid || (source_reg != s1_src);
    delta_cur  = DW'(s1_want) - DW'(shown_reg);
    delta_base = DW'(s1_want) - DW'(s1_base);
    delta_mag  = delta_cur[DW-1] ? DW'(-delta_cur) : DW'(delta_cur);
    big_step   = MW'(delta_mag) > MW'(large_step_limit);
    dir_neg    = delta_cur[DW-1];
    dir_nz     = delta_cur != '0;

    e_neg   = evidence_reg[EVID_W-1];
    e_mag   = e_neg ? EVID_W'(-evidence_reg) : EVID_W'(evidence_reg);
    lim_sum = EVID_W'(thr_level) + EVID_W'(inc_step);
    lim     = (lim_sum > EVID_MAX) ? EVID_MAX : lim_sum;
    grow    = (EVID_W+1)'(e_mag) + (EVID_W+1)'(inc_step);

    priority if (!dir_nz) begin
      g_mag = (e_mag > EVID_W'(zero_leak)) ? e_mag - EVID_W'(zero_leak) : '0;
      g_neg = e_neg;
    end else if ((e_mag == '0) || (e_neg == dir_neg)) begin
      g_mag = (grow > (EVID_W+1)'(lim)) ? lim : grow[EVID_W-1:0];
      g_neg = dir_neg;
    end else begin
      g_mag = (e_mag > EVID_W'(reverse_cancel)) ? e_mag - EVID_W'(reverse_cancel) : '0;
      g_neg = e_neg;
    end

    gather  = (s1_seq != last_seq_reg) && (s1_stable || !dir_nz);
    sel_mag = gather ? g_mag : e_mag;
    sel_neg = gather ? g_neg : e_neg;
    ev_sel  = sel_neg ? EVID_W'(-$signed(sel_mag)) : $signed(sel_mag);
    take_step = dir_nz && (sel_mag != '0) && (sel_neg == dir_neg) &&
                (sel_mag >= EVID_W'(thr_level));

    priority if (reinit) begin
      shown_next    = s1_base;
      evidence_next = '0;
      init_next     = s1_sample_valid;
      lock_next     = s1_sample_valid;
      jump_next     = 1'b0;
      delta_next    = delta_base;
    end else if (!s1_active) begin
      shown_next    = s1_base;
      evidence_next = '0;
      init_next     = 1'b1;
      lock_next     = 1'b0;
      jump_next     = 1'b0;
      delta_next    = delta_base;
    end else if (big_step) begin
      shown_next    = s1_want;
      evidence_next = '0;
      init_next     = 1'b1;
      lock_next     = 1'b0;
      jump_next     = 1'b1;
      delta_next    = '0;
    end else if (take_step) begin
      shown_next    = dir_neg ? shown_reg - CW'(1) : shown_reg + CW'(1);
      evidence_next = '0;
      init_next     = 1'b1;
      lock_next     = 1'b1;
      jump_next     = 1'b0;
      delta_next    = dir_neg ? delta_cur + DW'(1) : delta_cur - DW'(1);
    end else begin
      shown_next    = shown_reg;
      evidence_next = ev_sel;
      init_next     = 1'b1;
      lock_next     = 1'b1;
      jump_next     = 1'b0;
      delta_next    = delta_cur;
    end

    priority if (delta_next[DW-1]) begin
      dir_next = DIR_NEG;
    end else if (delta_next == '0) begin
      dir_next = DIR_ZERO;
    end else begin
      dir_next = DIR_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_reg    <= '0;
      evidence_reg <= '0;
      last_seq_reg <= '0;
      source_reg   <= '0;
      init_flag    <= 1'b0;
      lock_flag    <= 1'b0;
    end else if (s1_advance) begin
      shown_reg    <= shown_next;
      evidence_reg <= evidence_next;
      last_seq_reg <= s1_seq;
      source_reg   <= s1_src;
      init_flag    <= init_next;
      lock_flag    <= lock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      r_want   <= s1_want;
      r_shown  <= shown_next;
      r_delta  <= delta_next;
      r_evid   <= evidence_next;
      r_dir    <= dir_next;
      r_lock   <= lock_next;
      r_init   <= init_next;
      r_stable <= s1_stable;
      r_active <= s1_active;
      r_jump   <= jump_next;
    end
  end

  assign out_packed = {r_dir, r_evid, r_delta, r_shown, r_want};
  assign m_tdata    = OUT_W'(out_packed);
  assign m_tuser    = {r_jump, r_active, r_stable, r_init, r_lock};

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input not ready while output register is empty");

  a_jump_lands: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && r_jump) |-> (r_delta == '0 && !r_lock && r_init))
    else $error("jump result does not land on desired count");

  a_lock_needs_init: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && r_lock) |-> r_init)
    else $error("locked without initialized state");

  a_evidence_bound: assert property (@(posedge clk) disable iff (rst)
    evidence_reg != {1'b1, {(EVID_W-1){1'b0}}})
    else $error("evidence outside saturation bound");
`endif

endmodule
`default_nettype wire
